FILE: rtl/assert_macros.svh
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) not (prop)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, prop)
`endif

`endif

FILE: rtl/kci_pkg.sv
package kci_pkg;

   localparam int VAL_W     = 32;
   localparam int POS_W     = 16;
   localparam int MODE_W    = 2;
   localparam int PSQ_W     = 2 * POS_W - 1;
   localparam int PCU_W     = PSQ_W + POS_W;
   localparam int WGT_W     = 48;
   localparam int HALF_W    = 24;
   localparam int PROD_W    = 57;
   localparam int SUM_W     = 59;
   localparam int TOT_W     = 84;
   localparam int ONE_SHIFT = 45;
   localparam int LIN_SHIFT = 30;
   localparam int SQ_SHIFT  = 15;
   localparam int RND_W     = TOT_W - ONE_SHIFT;

   localparam logic [POS_W-1:0] POS_ONE = POS_W'(32768);

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic signed [WGT_W-1:0] wgt_type;

   localparam val_type VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam val_type VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [MODE_W-1:0] {
      MODE_HOLD    = 2'd0,
      MODE_LINEAR  = 2'd1,
      MODE_HERMITE = 2'd2,
      MODE_BEZIER  = 2'd3
   } mode_type;

   typedef struct packed {
      logic                valid;
      val_type       [3:0] vals;
      wgt_type       [3:0] wgts;
   } wgt_stage_type;

   typedef struct packed {
      logic                    valid;
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
   } sum_stage_type;

endpackage

FILE: rtl/kci_basis.sv
module kci_basis (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  kci_pkg::val_type            start_value,
   input  kci_pkg::val_type            out_tangent,
   input  kci_pkg::val_type            in_tangent,
   input  kci_pkg::val_type            end_value,
   input  logic [kci_pkg::POS_W-1:0]   position,
   input  logic [kci_pkg::MODE_W-1:0]  curve_mode,
   output kci_pkg::wgt_stage_type      wgt_out
);
   import kci_pkg::*;

   logic                    s1_valid_ff;
   val_type           [3:0] s1_vals_ff;
   logic [POS_W-1:0]        s1_pos_ff;
   logic [PSQ_W-1:0]        s1_psq_ff;
   mode_type                s1_mode_ff;

   logic                    s2_valid_ff;
   val_type           [3:0] s2_vals_ff;
   logic [POS_W-1:0]        s2_pos_ff;
   logic [PSQ_W-1:0]        s2_psq_ff;
   wgt_type                 s2_pcu_ff;
   mode_type                s2_mode_ff;

   wgt_stage_type           s3_ff;
   wgt_stage_type           s3_in;

   logic [POS_W-1:0]        pos_clamp;
   logic [2*POS_W-1:0]      psq_full;
   logic [PCU_W-1:0]        pcu_full;
   wgt_type                 t_one;
   wgt_type                 t_lin;
   wgt_type                 t_sq;
   wgt_type                 t_cu;

   // stage 1: clamp t and square it
   assign pos_clamp = (position > POS_ONE) ? POS_ONE : position;
   assign psq_full  = pos_clamp * pos_clamp;

   // stage 2: cube
   assign pcu_full  = s1_psq_ff * s1_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s1_vals_ff  <= {end_value, in_tangent, out_tangent, start_value};
         s1_pos_ff   <= pos_clamp;
         s1_psq_ff   <= psq_full[PSQ_W-1:0];
         s1_mode_ff  <= mode_type'(curve_mode);

         s2_valid_ff <= s1_valid_ff;
         s2_vals_ff  <= s1_vals_ff;
         s2_pos_ff   <= s1_pos_ff;
         s2_psq_ff   <= s1_psq_ff;
         s2_pcu_ff   <= wgt_type'(pcu_full);
         s2_mode_ff  <= s1_mode_ff;

         s3_ff       <= s3_in;
      end
   end

   // stage 3: basis weights in units of 2^-45
   assign t_one = wgt_type'(1) <<< ONE_SHIFT;
   assign t_lin = wgt_type'({s2_pos_ff, {LIN_SHIFT{1'b0}}});
   assign t_sq  = wgt_type'({s2_psq_ff, {SQ_SHIFT{1'b0}}});
   assign t_cu  = s2_pcu_ff;

   always_comb begin
      s3_in.valid = s2_valid_ff;
      s3_in.vals  = s2_vals_ff;
      case (s2_mode_ff)
         MODE_LINEAR: begin
            s3_in.wgts[0] = t_one - t_lin;
            s3_in.wgts[1] = '0;
            s3_in.wgts[2] = '0;
            s3_in.wgts[3] = t_lin;
         end
         MODE_HERMITE: begin
            s3_in.wgts[0] = (t_cu <<< 1) - (t_sq <<< 1) - t_sq + t_one;
            s3_in.wgts[1] = t_cu - (t_sq <<< 1) + t_lin;
            s3_in.wgts[2] = t_cu - t_sq;
            s3_in.wgts[3] = (t_sq <<< 1) + t_sq - (t_cu <<< 1);
         end
         MODE_BEZIER: begin
            s3_in.wgts[0] = t_one - (t_lin <<< 1) - t_lin + (t_sq <<< 1) + t_sq - t_cu;
            s3_in.wgts[1] = (t_lin <<< 1) + t_lin - (t_sq <<< 2) - (t_sq <<< 1)
                            + (t_cu <<< 1) + t_cu;
            s3_in.wgts[2] = (t_sq <<< 1) + t_sq - (t_cu <<< 1) - t_cu;
            s3_in.wgts[3] = t_cu;
         end
         default: begin
            s3_in.wgts[0] = t_one;
            s3_in.wgts[1] = '0;
            s3_in.wgts[2] = '0;
            s3_in.wgts[3] = '0;
         end
      endcase
   end

   assign wgt_out = s3_ff;

endmodule

FILE: rtl/kci_mac.sv
module kci_mac (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  kci_pkg::wgt_stage_type  wgt_in,
   output kci_pkg::sum_stage_type  sum_out
);
   import kci_pkg::*;

   logic                           s4_valid_ff;
   logic signed [3:0][PROD_W-1:0]  s4_hi_ff;
   logic signed [3:0][PROD_W-1:0]  s4_lo_ff;
   logic signed [3:0][PROD_W-1:0]  hi_in;
   logic signed [3:0][PROD_W-1:0]  lo_in;

   sum_stage_type                  s5_ff;
   sum_stage_type                  s5_in;

   // stage 4: each weight split into a signed upper and unsigned lower half
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         hi_in[i] = PROD_W'($signed(wgt_in.vals[i]))
                  * PROD_W'($signed(wgt_in.wgts[i][WGT_W-1:HALF_W]));
         lo_in[i] = PROD_W'($signed(wgt_in.vals[i]))
                  * PROD_W'($signed({1'b0, wgt_in.wgts[i][HALF_W-1:0]}));
      end
   end

   // stage 5: add the four terms of each half
   always_comb begin
      s5_in.valid = s4_valid_ff;
      s5_in.hi = SUM_W'($signed(s4_hi_ff[0])) + SUM_W'($signed(s4_hi_ff[1]))
               + SUM_W'($signed(s4_hi_ff[2])) + SUM_W'($signed(s4_hi_ff[3]));
      s5_in.lo = SUM_W'($signed(s4_lo_ff[0])) + SUM_W'($signed(s4_lo_ff[1]))
               + SUM_W'($signed(s4_lo_ff[2])) + SUM_W'($signed(s4_lo_ff[3]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_ff.valid <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= wgt_in.valid;
         s4_hi_ff    <= hi_in;
         s4_lo_ff    <= lo_in;
         s5_ff       <= s5_in;
      end
   end

   assign sum_out = s5_ff;

endmodule

FILE: rtl/keyframe_curve_interpolator_core.sv
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  start_value, out_tangent, in_tangent,
//                                           end_value, position, curve_mode
// rsp_      out        rsp_valid/rsp_stall  result_value, saturated
//
// one segment per cycle while req_stall is low; after its transfer a result is registered by each stage below in order
// stages: input/square, cube, basis weights, split products, sums, round and clip
// reset (synchronous) clears the valid bits of every stage, the output and the skid entry
// a stalled result moves the next one into a skid entry; req_stall is that entry's valid bit
// while req_stall is high the whole pipeline holds
`include "assert_macros.svh"

module keyframe_curve_interpolator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  kci_pkg::val_type            req_start_value,
   input  kci_pkg::val_type            req_out_tangent,
   input  kci_pkg::val_type            req_in_tangent,
   input  kci_pkg::val_type            req_end_value,
   input  logic [kci_pkg::POS_W-1:0]   req_position,
   input  logic [kci_pkg::MODE_W-1:0]  req_curve_mode,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output kci_pkg::val_type            rsp_result_value,
   output logic                        rsp_saturated
);
   import kci_pkg::*;

   logic                     advance;
   wgt_stage_type            wgt_stage;
   sum_stage_type            sum_stage;

   logic signed [TOT_W-1:0]  total;
   logic signed [RND_W-1:0]  rounded;
   logic                     clip;
   val_type                  new_value;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   val_type                  rsp_value_ff;
   val_type                  rsp_value_in;
   logic                     rsp_sat_ff;
   logic                     rsp_sat_in;
   logic                     skid_valid_ff;
   logic                     skid_valid_in;
   val_type                  skid_value_ff;
   val_type                  skid_value_in;
   logic                     skid_sat_ff;
   logic                     skid_sat_in;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   kci_basis u_basis (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .start_value (req_start_value),
      .out_tangent (req_out_tangent),
      .in_tangent  (req_in_tangent),
      .end_value   (req_end_value),
      .position    (req_position),
      .curve_mode  (req_curve_mode),
      .wgt_out     (wgt_stage)
   );

   kci_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .wgt_in  (wgt_stage),
      .sum_out (sum_stage)
   );

   // round to nearest, ties up, then clip to 32 bits
   assign total = (TOT_W'(sum_stage.hi) <<< HALF_W) + TOT_W'(sum_stage.lo)
                + (TOT_W'(1) <<< (ONE_SHIFT - 1));
   assign rounded = total[TOT_W-1:ONE_SHIFT];
   assign clip = (rounded[RND_W-1:VAL_W-1] != '0) && (rounded[RND_W-1:VAL_W-1] != '1);

   always_comb begin
      if (!clip) begin
         new_value = rounded[VAL_W-1:0];
      end else if (rounded[RND_W-1]) begin
         new_value = VAL_MIN;
      end else begin
         new_value = VAL_MAX;
      end
   end

   // output register plus skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_sat_in    = rsp_sat_ff;
      skid_valid_in = skid_valid_ff;
      skid_value_in = skid_value_ff;
      skid_sat_in   = skid_sat_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = skid_value_ff;
            rsp_sat_in    = skid_sat_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in  = sum_stage.valid;
            rsp_value_in  = new_value;
            rsp_sat_in    = clip;
         end
      end else if (advance && sum_stage.valid) begin
         skid_valid_in = 1'b1;
         skid_value_in = new_value;
         skid_sat_in   = clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_sat_ff    <= rsp_sat_in;
      skid_value_ff <= skid_value_in;
      skid_sat_ff   <= skid_sat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

   `ASSERT_HOLDS(skid_needs_output, clock, reset, skid_valid_ff |-> rsp_valid_ff)
   `ASSERT_HOLDS(skid_fills_on_stall, clock, reset, $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
   `ASSERT_HOLDS(clip_at_bound, clock, reset, (rsp_valid_ff && rsp_sat_ff) |-> (rsp_value_ff == VAL_MAX || rsp_value_ff == VAL_MIN))
   `ASSERT_NEVER(skid_overrun, clock, reset, skid_valid_ff && !advance && $past(skid_valid_ff) && rsp_valid_ff && !rsp_stall && $fell(rsp_valid_ff))

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import kci_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int DRAIN_CYCLES    = 20;
   localparam int ITEMS_PER_PHASE = 240;
   localparam int PRESSURE_ITEMS  = 40;
   localparam int NUM_DIRECTED    = 22;

   typedef struct packed {
      val_type          value;
      logic             sat;
   } curve_result_type;

   typedef struct packed {
      val_type          start_value;
      val_type          out_tangent;
      val_type          in_tangent;
      val_type          end_value;
      logic [POS_W-1:0] position;
      mode_type         mode;
      logic             typed;
      val_type          exp_value;
      logic             exp_sat;
   } segment_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   val_type          req_start_value = '0;
   val_type          req_out_tangent = '0;
   val_type          req_in_tangent = '0;
   val_type          req_end_value = '0;
   logic [POS_W-1:0] req_position = '0;
   logic [MODE_W-1:0] req_curve_mode = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   val_type          rsp_result_value;
   logic             rsp_saturated;

   curve_result_type pending_curve_values[$];
   segment_row_type  directed_table [0:NUM_DIRECTED-1];

   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               hold_off_seq = 0;
   int               hold_off_seen = 0;
   int               hold_off_left = 0;
   int               cycle_count = 0;
   int               error_count = 0;
   int               checked_count = 0;
   int               sat_count = 0;
   int               sent_count = 0;
   int               mode_count [4] = '{0, 0, 0, 0};

   keyframe_curve_interpolator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_value  (req_start_value),
      .req_out_tangent  (req_out_tangent),
      .req_in_tangent   (req_in_tangent),
      .req_end_value    (req_end_value),
      .req_position     (req_position),
      .req_curve_mode   (req_curve_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_saturated    (rsp_saturated)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // weighted basis sum, rounded half up to q16.16 and clipped
   function automatic curve_result_type eval_curve(input segment_row_type seg);
      val_type             vals [4];
      longint              wgt [4];
      longint              p;
      longint              s;
      longint              q;
      logic signed [95:0]  term_v;
      logic signed [95:0]  term_w;
      logic signed [95:0]  acc;
      curve_result_type    res;
      vals[0] = seg.start_value;
      vals[1] = seg.out_tangent;
      vals[2] = seg.in_tangent;
      vals[3] = seg.end_value;
      s = 32768;
      p = (seg.position > POS_ONE) ? s : longint'(seg.position);
      q = s - p;
      case (seg.mode)
         MODE_LINEAR: begin
            wgt[0] = s * s * s - p * s * s;
            wgt[1] = 0;
            wgt[2] = 0;
            wgt[3] = p * s * s;
         end
         MODE_HERMITE: begin
            wgt[0] = 2 * p * p * p - 3 * p * p * s + s * s * s;
            wgt[1] = p * p * p - 2 * p * p * s + p * s * s;
            wgt[2] = p * p * p - p * p * s;
            wgt[3] = 3 * p * p * s - 2 * p * p * p;
         end
         MODE_BEZIER: begin
            wgt[0] = q * q * q;
            wgt[1] = 3 * p * q * q;
            wgt[2] = 3 * p * p * q;
            wgt[3] = p * p * p;
         end
         default: begin
            wgt[0] = s * s * s;
            wgt[1] = 0;
            wgt[2] = 0;
            wgt[3] = 0;
         end
      endcase
      acc = '0;
      for (int i = 0; i < 4; i++) begin
         term_v = vals[i];
         term_w = wgt[i];
         acc = acc + term_v * term_w;
      end
      acc = (acc + (96'sd1 <<< 44)) >>> ONE_SHIFT;
      res.sat = 1'b0;
      if (acc > 96'sd2147483647) begin
         res.value = VAL_MAX;
         res.sat = 1'b1;
      end else if (acc < -96'sd2147483648) begin
         res.value = VAL_MIN;
         res.sat = 1'b1;
      end else begin
         res.value = acc[31:0];
      end
      return res;
   endfunction

   function automatic val_type rand_value();
      logic [31:0] x;
      x = $urandom;
      case ($urandom_range(0, 9))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2, 3: return {{12{x[31]}}, x[19:0]};
         default: return x;
      endcase
   endfunction

   function automatic segment_row_type rand_segment();
      segment_row_type seg;
      seg.start_value = rand_value();
      seg.out_tangent = rand_value();
      seg.in_tangent  = rand_value();
      seg.end_value   = rand_value();
      case ($urandom_range(0, 9))
         0: seg.position = '0;
         1: seg.position = POS_ONE;
         2, 3: seg.position = POS_W'($urandom_range(32769, 65535));
         default: seg.position = POS_W'($urandom_range(0, 32768));
      endcase
      seg.mode      = mode_type'($urandom_range(0, 3));
      seg.typed     = 1'b0;
      seg.exp_value = '0;
      seg.exp_sat   = 1'b0;
      return seg;
   endfunction

   task automatic send_segment(input segment_row_type seg);
      curve_result_type exp_res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_start_value <= seg.start_value;
      req_out_tangent <= seg.out_tangent;
      req_in_tangent  <= seg.in_tangent;
      req_end_value   <= seg.end_value;
      req_position    <= seg.position;
      req_curve_mode  <= seg.mode;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (seg.typed) begin
         exp_res.value = seg.exp_value;
         exp_res.sat   = seg.exp_sat;
      end else begin
         exp_res = eval_curve(seg);
      end
      pending_curve_values = {pending_curve_values, exp_res};
      sent_count++;
      mode_count[seg.mode]++;
   endtask

   task automatic wait_drained();
      while (pending_curve_values.size() != 0) @(posedge clock);
   endtask

   // output side back-pressure, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_off_seq != hold_off_seen) begin
         hold_off_seen <= hold_off_seq;
         hold_off_left <= HOLD_OFF_CYCLES;
         rsp_stall     <= 1'b1;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_stall     <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      curve_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_curve_values.size() == 0) begin
            $display("%0t: unexpected result transfer value %h sat %b",
                     $time, rsp_result_value, rsp_saturated);
            error_count++;
         end else begin
            exp_res = pending_curve_values.pop_front();
            checked_count++;
            if (rsp_saturated) sat_count++;
            if (rsp_result_value !== exp_res.value) begin
               $display("%0t: result_value mismatch expected %h actual %h",
                        $time, exp_res.value, rsp_result_value);
               error_count++;
            end
            if (rsp_saturated !== exp_res.sat) begin
               $display("%0t: saturated mismatch expected %b actual %b",
                        $time, exp_res.sat, rsp_saturated);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding",
                  $time, pending_curve_values.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      directed_table = '{
         // hold
         '{32'h12345678, VAL_MAX, VAL_MIN, 32'h0, 16'd0, MODE_HOLD,
           1'b1, 32'h12345678, 1'b0},
         '{VAL_MAX, 32'h0, 32'h0, VAL_MIN, POS_ONE, MODE_HOLD, 1'b1, VAL_MAX, 1'b0},
         '{VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX, 16'hFFFF, MODE_HOLD,
           1'b1, VAL_MIN, 1'b0},
         // linear, endpoints, clamp and rounding ties
         '{32'h00010000, 32'h0, 32'h0, 32'hFFFF0000, 16'd0, MODE_LINEAR,
           1'b1, 32'h00010000, 1'b0},
         '{VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, POS_ONE, MODE_LINEAR,
           1'b1, VAL_MAX, 1'b0},
         '{VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, 16'hFFFF, MODE_LINEAR,
           1'b1, VAL_MIN, 1'b0},
         '{32'h0, 32'h0, 32'h0, 32'h1, 16'd16384, MODE_LINEAR, 1'b1, 32'h1, 1'b0},
         '{32'h0, 32'h0, 32'h0, 32'hFFFFFFFF, 16'd16384, MODE_LINEAR,
           1'b1, 32'h0, 1'b0},
         '{VAL_MAX, 32'h0, 32'h0, VAL_MIN, 16'd16384, MODE_LINEAR, 1'b0, 32'h0, 1'b0},
         // hermite, endpoints, clamp and saturation both ways
         '{32'h00030000, VAL_MAX, VAL_MIN, 32'h0, 16'd0, MODE_HERMITE,
           1'b1, 32'h00030000, 1'b0},
         '{32'h00030000, VAL_MIN, VAL_MAX, 32'hFFFE8000, POS_ONE, MODE_HERMITE,
           1'b1, 32'hFFFE8000, 1'b0},
         '{VAL_MIN, VAL_MAX, VAL_MAX, 32'h7654ABCD, 16'h8001, MODE_HERMITE,
           1'b1, 32'h7654ABCD, 1'b0},
         '{VAL_MAX, VAL_MAX, VAL_MIN, VAL_MAX, 16'd16384, MODE_HERMITE,
           1'b1, VAL_MAX, 1'b1},
         '{VAL_MIN, VAL_MIN, VAL_MAX, VAL_MIN, 16'd16384, MODE_HERMITE,
           1'b1, VAL_MIN, 1'b1},
         '{32'h00020000, 32'hFFF80000, 32'h00050000, 32'hFFFF0000, 16'd10000,
           MODE_HERMITE, 1'b0, 32'h0, 1'b0},
         '{32'h00001234, VAL_MAX, VAL_MAX, 32'h0, 16'd1, MODE_HERMITE,
           1'b0, 32'h0, 1'b0},
         '{VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, 16'd32767, MODE_HERMITE,
           1'b0, 32'h0, 1'b0},
         // bezier
         '{32'hFFFFFFFB, VAL_MAX, VAL_MAX, VAL_MAX, 16'd0, MODE_BEZIER,
           1'b1, 32'hFFFFFFFB, 1'b0},
         '{VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, POS_ONE, MODE_BEZIER,
           1'b1, VAL_MIN, 1'b0},
         '{VAL_MIN, VAL_MIN, VAL_MIN, 32'h00000007, 16'hC000, MODE_BEZIER,
           1'b1, 32'h00000007, 1'b0},
         '{VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, 16'd12345, MODE_BEZIER,
           1'b0, 32'h0, 1'b0},
         '{VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, 16'd1, MODE_BEZIER, 1'b0, 32'h0, 1'b0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) send_segment(directed_table[i]);

      // idle mixes: none, sender idle, receiver stalls, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 81 : (phase == 3) ? 19 : 0;
         recv_stall_pct = (phase == 2) ? 81 : (phase == 3) ? 19 : 0;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send_segment(rand_segment());
         req_valid <= 1'b0;
         wait_drained();
      end

      // long output hold-off with a full rate sender
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_seq++;
      for (int i = 0; i < PRESSURE_ITEMS; i++) send_segment(rand_segment());
      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d segments: hold %0d, linear %0d, hermite %0d, bezier %0d",
               sent_count, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
      $display("checked %0d results (%0d saturated) under four idle mixes and a hold-off",
               checked_count, sat_count);
      if (error_count == 0 && pending_curve_values.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
